// ===== hw/rtl/gaussian_lobe_ward_reducer_unit_defines.svh =====
// assertion macros for the gaussian lobe reducer
// expects clk and rst_n in the scope where a macro is used
`ifndef GAUSSIAN_LOBE_WARD_REDUCER_UNIT_DEFINES_SVH
`define GAUSSIAN_LOBE_WARD_REDUCER_UNIT_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define GLW_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define GLW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/glw_pkg.sv =====
// shared types and constants of the gaussian lobe reducer
// no dependencies
`default_nettype none

package glw_pkg;

  localparam int MAX_LOBES = 4;
  localparam int CAPACITY  = 2 * MAX_LOBES;
  localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int TGT_W     = 3;
  localparam logic [TGT_W-1:0] TARGET_RST = 3'd2;

  // restoring divider: quotient always fits 32 bits
  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  // one stored lobe, all Q16.16
  typedef struct packed {
    logic [31:0] power;
    logic [31:0] mean_x;
    logic [31:0] mean_y;
    logic [31:0] mean_z;
    logic [31:0] spread;
    logic [31:0] low_x;
    logic [31:0] low_y;
    logic [31:0] low_z;
    logic [31:0] high_x;
    logic [31:0] high_y;
    logic [31:0] high_z;
  } lobe_t;

  // divider status seen by the sequencer
  typedef struct packed {
    logic        busy;
    logic [31:0] quotient;
  } div_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/glw_lobe_ram.sv =====
// lobe store: one write port, two registered read ports
// depends on glw_pkg
`default_nettype none

module glw_lobe_ram (
  input  wire logic                     clk,
  input  wire logic [glw_pkg::IDX_W-1:0] rd_addr_a,
  input  wire logic [glw_pkg::IDX_W-1:0] rd_addr_b,
  output glw_pkg::lobe_t                rd_data_a,
  output glw_pkg::lobe_t                rd_data_b,
  input  wire logic                     wr_en,
  input  wire logic [glw_pkg::IDX_W-1:0] wr_addr,
  input  glw_pkg::lobe_t                wr_data
);

  glw_pkg::lobe_t mem [glw_pkg::CAPACITY];

  // write and registered reads
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/glw_divider.sv =====
// iterative restoring divider, one quotient bit per cycle
// depends on glw_pkg; requires dividend[63:32] < divisor
`default_nettype none

module glw_divider (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [63:0]   dividend,
  input  wire logic [32:0]   divisor,
  output glw_pkg::div_status_t status
);

  logic [32:0]                   rem_r;
  logic [31:0]                   quo_r;
  logic [glw_pkg::DIV_CNT_W-1:0] step_r;
  logic                          busy_r;
  logic [33:0]                   trial_w;
  logic [33:0]                   diff_w;
  logic                          fits_w;

  // trial subtract of the shifted remainder
  always_comb begin
    trial_w = {rem_r, quo_r[31]};
    diff_w  = trial_w - {1'b0, divisor};
    fits_w  = (trial_w >= {1'b0, divisor});
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      step_r <= glw_pkg::DIV_CNT_W'(glw_pkg::DIV_STEPS);
    end else if (busy_r) begin
      step_r <= step_r - 1'b1;
      if (step_r == glw_pkg::DIV_CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, dividend[63:32]};
      quo_r <= dividend[31:0];
    end else if (busy_r) begin
      rem_r <= fits_w ? diff_w[32:0] : trial_w[32:0];
      quo_r <= {quo_r[30:0], fits_w};
    end
  end

  assign status.busy     = busy_r;
  assign status.quotient = quo_r;

endmodule

`default_nettype wire

// ===== hw/rtl/gaussian_lobe_ward_reducer_unit.sv =====
// Gaussian lobe reducer: loads a set of lobes one word per start pulse, then reduces the
// set by Ward merging down to target_lobes and emits the survivors by descending power.
// A lobe word is taken at a start pulse while idle; a word without last_lobe leaves busy low.
// The word marked last_lobe raises busy for the whole reduction: each pair cost waits on
// the shared divider; each merge uses six divides on the shared divider, then moves the
// later lobes down one place; output scans all survivors in the store for each lobe sent.
// Results are one-cycle strobes on out_valid
// that the receiver must take; out_last marks the final one. No clearing pass after reset.
// depends on glw_pkg, glw_lobe_ram, glw_divider and the defines header
`default_nettype none

`include "gaussian_lobe_ward_reducer_unit_defines.svh"

module gaussian_lobe_ward_reducer_unit (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic        [31:0]          in_power,
  input  wire logic signed [31:0]          in_mean_x,
  input  wire logic signed [31:0]          in_mean_y,
  input  wire logic signed [31:0]          in_mean_z,
  input  wire logic        [31:0]          in_spread,
  input  wire logic signed [31:0]          in_box_low_x,
  input  wire logic signed [31:0]          in_box_low_y,
  input  wire logic signed [31:0]          in_box_low_z,
  input  wire logic signed [31:0]          in_box_high_x,
  input  wire logic signed [31:0]          in_box_high_y,
  input  wire logic signed [31:0]          in_box_high_z,
  input  wire logic                        in_last_lobe,
  output logic                             out_valid,
  output logic             [31:0]          out_power,
  output logic signed      [31:0]          out_mean_x,
  output logic signed      [31:0]          out_mean_y,
  output logic signed      [31:0]          out_mean_z,
  output logic             [31:0]          out_spread,
  output logic signed      [31:0]          out_low_x,
  output logic signed      [31:0]          out_low_y,
  output logic signed      [31:0]          out_low_z,
  output logic signed      [31:0]          out_high_x,
  output logic signed      [31:0]          out_high_y,
  output logic signed      [31:0]          out_high_z,
  output logic                             out_last,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [glw_pkg::TGT_W-1:0]   cfg_data
);

  localparam int IDX_W = glw_pkg::IDX_W;
  localparam int CNT_W = glw_pkg::CNT_W;

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_PRD  = 5'd1;
  localparam logic [4:0] ST_PLD  = 5'd2;
  localparam logic [4:0] ST_AMP  = 5'd3;
  localparam logic [4:0] ST_ADIV = 5'd4;
  localparam logic [4:0] ST_ASQ  = 5'd5;
  localparam logic [4:0] ST_AHW  = 5'd6;
  localparam logic [4:0] ST_CM0  = 5'd7;
  localparam logic [4:0] ST_CM1  = 5'd8;
  localparam logic [4:0] ST_CMP  = 5'd9;
  localparam logic [4:0] ST_MRD  = 5'd10;
  localparam logic [4:0] ST_MLD  = 5'd11;
  localparam logic [4:0] ST_MFR  = 5'd12;
  localparam logic [4:0] ST_MFW  = 5'd13;
  localparam logic [4:0] ST_MX0  = 5'd14;
  localparam logic [4:0] ST_MX1  = 5'd15;
  localparam logic [4:0] ST_MX2  = 5'd16;
  localparam logic [4:0] ST_MBM  = 5'd17;
  localparam logic [4:0] ST_MBD  = 5'd18;
  localparam logic [4:0] ST_MBW  = 5'd19;
  localparam logic [4:0] ST_MWR  = 5'd20;
  localparam logic [4:0] ST_CRD  = 5'd21;
  localparam logic [4:0] ST_CWR  = 5'd22;
  localparam logic [4:0] ST_OSA  = 5'd23;
  localparam logic [4:0] ST_OSB  = 5'd24;
  localparam logic [4:0] ST_ORD  = 5'd25;
  localparam logic [4:0] ST_OEM  = 5'd26;

  logic [4:0]                state_r;
  logic [glw_pkg::TGT_W-1:0] target_r;
  logic [CNT_W-1:0]          fill_r;
  logic [CNT_W-1:0]          count_r;
  logic [CNT_W-1:0]          tgt_r;
  logic [IDX_W-1:0]          i_r, j_r, bi_r, bj_r, c_r, sk_r, sel_r;
  logic                      found_r, merge_r, have_r;
  logic [63:0]               best_r, prod_r, acc_r, p0_r, extra_r;
  logic [1:0]                sqk_r, bk_r;
  logic [31:0]               h_r, bestp_r;
  logic [15:0]               frac_r;
  logic [31:0]               bres_r [4];
  logic [glw_pkg::CAPACITY-1:0] emitted_r;
  logic [CNT_W-1:0]          emit_n_r;
  glw_pkg::lobe_t            la_r, lb_r, olobe_r;
  logic                      out_valid_r, out_last_r;

  glw_pkg::lobe_t            rdata_a, rdata_b, wr_data_w, in_lobe_w, merged_w;
  logic [IDX_W-1:0]          ra_addr_w, rb_addr_w, wr_addr_w;
  logic                      wr_en_w;
  logic                      accept_w;
  logic [CNT_W-1:0]          cnt_new_w, tgt_w;
  logic [3:0]                t4_w;
  logic [32:0]               psum_w;
  logic                      pzero_w;
  logic [31:0]               adx_w, ady_w, adz_w;
  logic [47:0]               dq_w;
  logic [31:0]               mul_a_w, mul_b_w;
  logic [64:0]               acc_sum_w;
  logic [96:0]               wide_w;
  logic [63:0]               cost_w;
  logic [32:0]               ba_w, bb_w, bdiff_w, bneg_w, bmagx_w, bres_w;
  logic [31:0]               bmag_w;
  logic [64:0]               ssum_w;
  logic                      div_start_w;
  logic [63:0]               div_dividend_w;
  glw_pkg::div_status_t      div_st;
  logic [CNT_W-1:0]          count_dec_w;

  // magnitude of a signed difference, always below 2^32
  function automatic logic [31:0] mag_diff(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] d;
    logic [32:0] n;
    d = {a[31], a} - {b[31], b};
    n = -d;
    mag_diff = d[32] ? n[31:0] : d[31:0];
  endfunction

  // lobe store
  glw_lobe_ram u_ram (
    .clk       (clk),
    .rd_addr_a (ra_addr_w),
    .rd_addr_b (rb_addr_w),
    .rd_data_a (rdata_a),
    .rd_data_b (rdata_b),
    .wr_en     (wr_en_w),
    .wr_addr   (wr_addr_w),
    .wr_data   (wr_data_w)
  );

  // shared divider, divisor is always the summed power
  glw_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_w),
    .dividend (div_dividend_w),
    .divisor  (psum_w),
    .status   (div_st)
  );

  assign accept_w  = start && !busy;
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  // incoming word as a lobe
  always_comb begin
    in_lobe_w.power  = in_power;
    in_lobe_w.mean_x = in_mean_x;
    in_lobe_w.mean_y = in_mean_y;
    in_lobe_w.mean_z = in_mean_z;
    in_lobe_w.spread = in_spread;
    in_lobe_w.low_x  = in_box_low_x;
    in_lobe_w.low_y  = in_box_low_y;
    in_lobe_w.low_z  = in_box_low_z;
    in_lobe_w.high_x = in_box_high_x;
    in_lobe_w.high_y = in_box_high_y;
    in_lobe_w.high_z = in_box_high_z;
  end

  // clamp target into 1..MAX_LOBES, set size at end of load
  always_comb begin
    t4_w = {1'b0, target_r};
    if (t4_w == 4'd0) begin
      t4_w = 4'd1;
    end else if (t4_w > 4'(glw_pkg::MAX_LOBES)) begin
      t4_w = 4'(glw_pkg::MAX_LOBES);
    end
    tgt_w     = CNT_W'(t4_w);
    cnt_new_w = (fill_r < CNT_W'(glw_pkg::CAPACITY)) ? fill_r + 1'b1
                                                      : CNT_W'(glw_pkg::CAPACITY);
    count_dec_w = count_r - 1'b1;
  end

  // pair terms
  always_comb begin
    psum_w  = {1'b0, la_r.power} + {1'b0, lb_r.power};
    pzero_w = (psum_w == 33'd0);
    adx_w   = mag_diff(la_r.mean_x, lb_r.mean_x);
    ady_w   = mag_diff(la_r.mean_y, lb_r.mean_y);
    adz_w   = mag_diff(la_r.mean_z, lb_r.mean_z);
    dq_w    = acc_r[63:16];
  end

  // blend operands: x, y, z means then spread
  always_comb begin
    case (bk_r)
      2'd0:    begin ba_w = {la_r.mean_x[31], la_r.mean_x}; bb_w = {lb_r.mean_x[31], lb_r.mean_x}; end
      2'd1:    begin ba_w = {la_r.mean_y[31], la_r.mean_y}; bb_w = {lb_r.mean_y[31], lb_r.mean_y}; end
      2'd2:    begin ba_w = {la_r.mean_z[31], la_r.mean_z}; bb_w = {lb_r.mean_z[31], lb_r.mean_z}; end
      default: begin ba_w = {1'b0, la_r.spread};            bb_w = {1'b0, lb_r.spread};            end
    endcase
    bdiff_w = bb_w - ba_w;
    bneg_w  = -bdiff_w;
    bmagx_w = bdiff_w[32] ? bneg_w : bdiff_w;
    bmag_w  = bmagx_w[31:0];
    bres_w  = bdiff_w[32] ? (ba_w - {1'b0, div_st.quotient})
                          : (ba_w + {1'b0, div_st.quotient});
  end

  // multiplier operand select
  always_comb begin
    mul_a_w = 32'd0;
    mul_b_w = 32'd0;
    unique case (state_r)
      ST_AMP:  begin mul_a_w = la_r.power; mul_b_w = lb_r.power; end
      ST_ADIV: begin mul_a_w = adx_w; mul_b_w = adx_w; end
      ST_ASQ: begin
        if (sqk_r == 2'd1) begin
          mul_a_w = ady_w; mul_b_w = ady_w;
        end else if (sqk_r == 2'd2) begin
          mul_a_w = adz_w; mul_b_w = adz_w;
        end
      end
      ST_CM0:  begin mul_a_w = h_r; mul_b_w = dq_w[31:0]; end
      ST_CM1:  begin mul_a_w = h_r; mul_b_w = {16'd0, dq_w[47:32]}; end
      ST_MX0:  begin mul_a_w = {16'd0, frac_r}; mul_b_w = dq_w[31:0]; end
      ST_MX1:  begin mul_a_w = {16'd0, frac_r}; mul_b_w = {16'd0, dq_w[47:32]}; end
      ST_MBM:  begin mul_a_w = bmag_w; mul_b_w = lb_r.power; end
      default: begin mul_a_w = 32'd0; mul_b_w = 32'd0; end
    endcase
  end

  // registered product
  always_ff @(posedge clk) begin
    prod_r <= mul_a_w * mul_b_w;
  end

  // saturating sums: square accumulate, split product recombine, spread
  always_comb begin
    acc_sum_w = {1'b0, acc_r} + {1'b0, prod_r};
    wide_w    = {33'd0, p0_r} + {1'b0, prod_r, 32'd0};
    if (pzero_w) begin
      cost_w = 64'd0;
    end else if (|wide_w[96:64]) begin
      cost_w = '1;
    end else begin
      cost_w = wide_w[63:0];
    end
    ssum_w = {33'd0, bres_r[3]} + {1'b0, extra_r};
  end

  // merged lobe
  always_comb begin
    merged_w.low_x  = ($signed(la_r.low_x) < $signed(lb_r.low_x)) ? la_r.low_x : lb_r.low_x;
    merged_w.low_y  = ($signed(la_r.low_y) < $signed(lb_r.low_y)) ? la_r.low_y : lb_r.low_y;
    merged_w.low_z  = ($signed(la_r.low_z) < $signed(lb_r.low_z)) ? la_r.low_z : lb_r.low_z;
    merged_w.high_x = ($signed(la_r.high_x) > $signed(lb_r.high_x)) ? la_r.high_x : lb_r.high_x;
    merged_w.high_y = ($signed(la_r.high_y) > $signed(lb_r.high_y)) ? la_r.high_y : lb_r.high_y;
    merged_w.high_z = ($signed(la_r.high_z) > $signed(lb_r.high_z)) ? la_r.high_z : lb_r.high_z;
    if (pzero_w) begin
      merged_w.power  = 32'd0;
      merged_w.mean_x = 32'd0;
      merged_w.mean_y = 32'd0;
      merged_w.mean_z = 32'd0;
      merged_w.spread = 32'd0;
    end else begin
      merged_w.power  = psum_w[32] ? 32'hFFFF_FFFF : psum_w[31:0];
      merged_w.mean_x = bres_r[0];
      merged_w.mean_y = bres_r[1];
      merged_w.mean_z = bres_r[2];
      merged_w.spread = (|ssum_w[64:32]) ? 32'hFFFF_FFFF : ssum_w[31:0];
    end
  end

  // store address and write select
  always_comb begin
    ra_addr_w = i_r;
    rb_addr_w = j_r;
    wr_en_w   = 1'b0;
    wr_addr_w = fill_r[IDX_W-1:0];
    wr_data_w = in_lobe_w;
    unique case (state_r)
      ST_IDLE: begin
        wr_en_w = accept_w && (fill_r < CNT_W'(glw_pkg::CAPACITY));
      end
      ST_MRD: begin
        ra_addr_w = bi_r;
        rb_addr_w = bj_r;
      end
      ST_MWR: begin
        wr_en_w   = 1'b1;
        wr_addr_w = bi_r;
        wr_data_w = merged_w;
      end
      ST_CRD:  ra_addr_w = IDX_W'(c_r + 1'b1);
      ST_CWR: begin
        wr_en_w   = 1'b1;
        wr_addr_w = c_r;
        wr_data_w = rdata_a;
      end
      ST_OSA:  ra_addr_w = sk_r;
      ST_ORD:  ra_addr_w = sel_r;
      default: ra_addr_w = i_r;
    endcase
  end

  // divider start and dividend
  always_comb begin
    div_start_w    = (state_r == ST_ADIV) || (state_r == ST_MFR) || (state_r == ST_MBD);
    div_dividend_w = (state_r == ST_MFR) ? {16'd0, h_r, 16'd0} : prod_r;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      target_r    <= glw_pkg::TARGET_RST;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == ST_OEM);
      if (cfg_valid && cfg_ready) begin
        target_r <= cfg_data;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept_w) begin
            if (in_last_lobe) begin
              fill_r  <= '0;
              count_r <= cnt_new_w;
              tgt_r   <= tgt_w;
              if (cnt_new_w > tgt_w) begin
                i_r     <= '0;
                j_r     <= IDX_W'(1);
                found_r <= 1'b0;
                state_r <= ST_PRD;
              end else begin
                emitted_r <= '0;
                emit_n_r  <= '0;
                sk_r      <= '0;
                have_r    <= 1'b0;
                state_r   <= ST_OSA;
              end
            end else if (fill_r < CNT_W'(glw_pkg::CAPACITY)) begin
              fill_r <= fill_r + 1'b1;
            end
          end
        end
        ST_PRD: state_r <= ST_PLD;
        ST_PLD: begin
          la_r    <= rdata_a;
          lb_r    <= rdata_b;
          merge_r <= 1'b0;
          state_r <= ST_AMP;
        end
        ST_AMP: begin
          acc_r   <= '0;
          state_r <= ST_ADIV;
        end
        ST_ADIV: begin
          sqk_r   <= 2'd1;
          state_r <= ST_ASQ;
        end
        // accumulate the three squared axis differences
        ST_ASQ: begin
          acc_r <= acc_sum_w[64] ? '1 : acc_sum_w[63:0];
          sqk_r <= sqk_r + 1'b1;
          if (sqk_r == 2'd3) begin
            state_r <= ST_AHW;
          end
        end
        ST_AHW: begin
          if (!div_st.busy) begin
            h_r     <= div_st.quotient;
            state_r <= merge_r ? ST_MFR : ST_CM0;
          end
        end
        ST_CM0: state_r <= ST_CM1;
        ST_CM1: begin
          p0_r    <= prod_r;
          state_r <= ST_CMP;
        end
        // keep the earliest lowest-cost pair, step to the next pair
        ST_CMP: begin
          if (!found_r || (cost_w < best_r)) begin
            found_r <= 1'b1;
            best_r  <= cost_w;
            bi_r    <= i_r;
            bj_r    <= j_r;
          end
          if (CNT_W'(j_r) + 1'b1 == count_r) begin
            if (CNT_W'(i_r) + 2'd2 == count_r) begin
              state_r <= ST_MRD;
            end else begin
              i_r     <= i_r + 1'b1;
              j_r     <= IDX_W'(i_r + 2'd2);
              state_r <= ST_PRD;
            end
          end else begin
            j_r     <= j_r + 1'b1;
            state_r <= ST_PRD;
          end
        end
        ST_MRD: state_r <= ST_MLD;
        ST_MLD: begin
          la_r    <= rdata_a;
          lb_r    <= rdata_b;
          merge_r <= 1'b1;
          state_r <= ST_AMP;
        end
        ST_MFR: state_r <= ST_MFW;
        ST_MFW: begin
          if (!div_st.busy) begin
            frac_r  <= div_st.quotient[15:0];
            state_r <= ST_MX0;
          end
        end
        ST_MX0: state_r <= ST_MX1;
        ST_MX1: begin
          p0_r    <= prod_r;
          state_r <= ST_MX2;
        end
        ST_MX2: begin
          extra_r <= wide_w[79:16];
          bk_r    <= 2'd0;
          state_r <= ST_MBM;
        end
        ST_MBM: state_r <= ST_MBD;
        ST_MBD: state_r <= ST_MBW;
        ST_MBW: begin
          if (!div_st.busy) begin
            bres_r[bk_r] <= bres_w[31:0];
            if (bk_r == 2'd3) begin
              state_r <= ST_MWR;
            end else begin
              bk_r    <= bk_r + 1'b1;
              state_r <= ST_MBM;
            end
          end
        end
        ST_MWR: begin
          c_r     <= bj_r;
          state_r <= ST_CRD;
        end
        // close the gap left by the second lobe of the pair
        ST_CRD: begin
          if (CNT_W'(c_r) + 1'b1 < count_r) begin
            state_r <= ST_CWR;
          end else begin
            count_r <= count_dec_w;
            if (count_dec_w > tgt_r) begin
              i_r     <= '0;
              j_r     <= IDX_W'(1);
              found_r <= 1'b0;
              state_r <= ST_PRD;
            end else begin
              emitted_r <= '0;
              emit_n_r  <= '0;
              sk_r      <= '0;
              have_r    <= 1'b0;
              state_r   <= ST_OSA;
            end
          end
        end
        ST_CWR: begin
          c_r     <= c_r + 1'b1;
          state_r <= ST_CRD;
        end
        ST_OSA: state_r <= ST_OSB;
        // first strongest lobe not yet sent
        ST_OSB: begin
          if (!emitted_r[sk_r] && (!have_r || (rdata_a.power > bestp_r))) begin
            have_r  <= 1'b1;
            bestp_r <= rdata_a.power;
            sel_r   <= sk_r;
          end
          if (CNT_W'(sk_r) + 1'b1 == count_r) begin
            state_r <= ST_ORD;
          end else begin
            sk_r    <= sk_r + 1'b1;
            state_r <= ST_OSA;
          end
        end
        ST_ORD: state_r <= ST_OEM;
        ST_OEM: begin
          olobe_r          <= rdata_a;
          out_last_r       <= (emit_n_r + 1'b1 == count_r);
          emitted_r[sel_r] <= 1'b1;
          emit_n_r         <= emit_n_r + 1'b1;
          if (emit_n_r + 1'b1 == count_r) begin
            state_r <= ST_IDLE;
          end else begin
            sk_r    <= '0;
            have_r  <= 1'b0;
            state_r <= ST_OSA;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // result ports
  assign out_valid  = out_valid_r;
  assign out_last   = out_last_r;
  assign out_power  = olobe_r.power;
  assign out_mean_x = $signed(olobe_r.mean_x);
  assign out_mean_y = $signed(olobe_r.mean_y);
  assign out_mean_z = $signed(olobe_r.mean_z);
  assign out_spread = olobe_r.spread;
  assign out_low_x  = $signed(olobe_r.low_x);
  assign out_low_y  = $signed(olobe_r.low_y);
  assign out_low_z  = $signed(olobe_r.low_z);
  assign out_high_x = $signed(olobe_r.high_x);
  assign out_high_y = $signed(olobe_r.high_y);
  assign out_high_z = $signed(olobe_r.high_z);

  // checks
  `GLW_ASSERT_SAME(a_div_free, div_start_w, !div_st.busy, "divider restarted while busy")
  `GLW_ASSERT_SAME(a_last_ends, out_valid && out_last, state_r == ST_IDLE, "set not closed on last word")
  `GLW_ASSERT_SAME(a_more_busy, out_valid && !out_last, busy, "left busy before last word")
  `GLW_ASSERT_NEXT(a_word_gap, out_valid, !out_valid, "result words back to back")

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// testbench for the gaussian lobe reducer: drives lobe words, predicts Ward merging
// in a scoreboard class and checks every result word field by field
// depends on glw_pkg and gaussian_lobe_ward_reducer_unit
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import glw_pkg::*;

  localparam int NUM_SETS = 52;

  // prediction of the reducer and the queue of expected result words
  class lobe_scoreboard;
    lobe_t stored[CAPACITY];
    int unsigned fill;
    int unsigned target_reg;
    lobe_t expected_q[$];
    bit expected_last_q[$];
    int errors;

    function new();
      fill = 0;
      target_reg = TARGET_RST;
      errors = 0;
    endfunction

    function automatic logic [63:0] dist2(lobe_t a, lobe_t b);
      logic [64:0] acc;
      logic signed [33:0] d;
      logic [33:0] ad;
      logic [63:0] sq;
      acc = 0;
      for (int k = 0; k < 3; k++) begin
        case (k)
          0: d = $signed(a.mean_x) - $signed(b.mean_x);
          1: d = $signed(a.mean_y) - $signed(b.mean_y);
          default: d = $signed(a.mean_z) - $signed(b.mean_z);
        endcase
        ad = d < 0 ? -d : d;
        sq = ad * ad;
        acc = acc + sq;
        if (acc[64]) acc = {1'b0, 64'hFFFF_FFFF_FFFF_FFFF};
      end
      return acc[63:0];
    endfunction

    function automatic logic [63:0] cost(lobe_t a, lobe_t b);
      logic [63:0] sum, h, dq;
      logic [127:0] prod;
      sum = {32'b0, a.power} + {32'b0, b.power};
      if (sum == 0) return 0;
      h = ({32'b0, a.power} * {32'b0, b.power}) / sum;
      dq = dist2(a, b) >> 16;
      prod = h * dq;
      if (prod[127:64] != 0) return 64'hFFFF_FFFF_FFFF_FFFF;
      return prod[63:0];
    endfunction

    // a + trunc(w*(b-a)/sum)
    function automatic logic signed [63:0] blend(logic signed [63:0] a, logic signed [63:0] b,
                                                 logic [63:0] w, logic [63:0] sum);
      logic signed [63:0] d;
      d = b - a;
      if (d >= 0) return a + $signed((d * w) / sum);
      return a - $signed(((-d) * w) / sum);
    endfunction

    function automatic lobe_t combine(lobe_t a, lobe_t b);
      lobe_t r;
      logic [63:0] sum, h, frac, extra, base, s;
      r = '0;
      r.low_x = $signed(a.low_x) < $signed(b.low_x) ? a.low_x : b.low_x;
      r.low_y = $signed(a.low_y) < $signed(b.low_y) ? a.low_y : b.low_y;
      r.low_z = $signed(a.low_z) < $signed(b.low_z) ? a.low_z : b.low_z;
      r.high_x = $signed(a.high_x) > $signed(b.high_x) ? a.high_x : b.high_x;
      r.high_y = $signed(a.high_y) > $signed(b.high_y) ? a.high_y : b.high_y;
      r.high_z = $signed(a.high_z) > $signed(b.high_z) ? a.high_z : b.high_z;
      sum = {32'b0, a.power} + {32'b0, b.power};
      if (sum == 0) return r;
      h = ({32'b0, a.power} * {32'b0, b.power}) / sum;
      frac = (h << 16) / sum;
      extra = (frac * (dist2(a, b) >> 16)) >> 16;
      base = blend({32'b0, a.spread}, {32'b0, b.spread}, {32'b0, b.power}, sum);
      s = base + extra;
      r.mean_x = 32'(blend(64'($signed(a.mean_x)), 64'($signed(b.mean_x)),
                           {32'b0, b.power}, sum));
      r.mean_y = 32'(blend(64'($signed(a.mean_y)), 64'($signed(b.mean_y)),
                           {32'b0, b.power}, sum));
      r.mean_z = 32'(blend(64'($signed(a.mean_z)), 64'($signed(b.mean_z)),
                           {32'b0, b.power}, sum));
      r.spread = s > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : s[31:0];
      r.power = sum > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : sum[31:0];
      return r;
    endfunction

    // note one accepted lobe word
    function void note_lobe(lobe_t l, bit last);
      lobe_t work[$];
      lobe_t key;
      int unsigned tgt, bi, bj;
      logic [63:0] best, c;
      int j;
      if (fill < CAPACITY) begin
        stored[fill] = l;
        fill++;
      end
      if (!last) return;
      for (int i = 0; i < fill; i++) work.insert(work.size(), stored[i]);
      fill = 0;
      tgt = target_reg < 1 ? 1 : (target_reg > MAX_LOBES ? MAX_LOBES : target_reg);
      while (work.size() > tgt) begin
        bi = 0; bj = 1; best = cost(work[0], work[1]);
        for (int i = 0; i < work.size(); i++)
          for (int k = i + 1; k < work.size(); k++) begin
            c = cost(work[i], work[k]);
            if (c < best) begin
              best = c; bi = i; bj = k;
            end
          end
        work[bi] = combine(work[bi], work[bj]);
        work.delete(bj);
      end
      // stable sort, descending power
      for (int i = 1; i < work.size(); i++) begin
        key = work[i];
        j = i;
        while (j > 0 && work[j-1].power < key.power) begin
          work[j] = work[j-1];
          j--;
        end
        work[j] = key;
      end
      foreach (work[i]) begin
        expected_q.insert(expected_q.size(), work[i]);
        expected_last_q.insert(expected_last_q.size(), i == work.size() - 1);
      end
    endfunction

    // check one result word against the oldest expectation
    function void check_result(lobe_t got, bit got_last);
      lobe_t e;
      bit el;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result word power=%h", $realtime, got.power);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      el = expected_last_q.pop_front();
      if (e.power != got.power) report("power", e.power, got.power);
      if (e.mean_x != got.mean_x) report("mean_x", e.mean_x, got.mean_x);
      if (e.mean_y != got.mean_y) report("mean_y", e.mean_y, got.mean_y);
      if (e.mean_z != got.mean_z) report("mean_z", e.mean_z, got.mean_z);
      if (e.spread != got.spread) report("spread", e.spread, got.spread);
      if (e.low_x != got.low_x) report("low_x", e.low_x, got.low_x);
      if (e.low_y != got.low_y) report("low_y", e.low_y, got.low_y);
      if (e.low_z != got.low_z) report("low_z", e.low_z, got.low_z);
      if (e.high_x != got.high_x) report("high_x", e.high_x, got.high_x);
      if (e.high_y != got.high_y) report("high_y", e.high_y, got.high_y);
      if (e.high_z != got.high_z) report("high_z", e.high_z, got.high_z);
      if (el != got_last) report("last", el, got_last);
    endfunction

    function void report(string field, logic [31:0] exp_v, logic [31:0] act_v);
      $display("%0t: mismatch %s expected %h actual %h", $realtime, field, exp_v, act_v);
      errors++;
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  lobe_t drv = '0;
  logic in_last_lobe = 0;
  logic out_valid, out_last;
  logic [31:0] out_power, out_mean_x, out_mean_y, out_mean_z, out_spread;
  logic [31:0] out_low_x, out_low_y, out_low_z, out_high_x, out_high_y, out_high_z;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [TGT_W-1:0] cfg_data = '0;

  lobe_scoreboard sb = new();

  always #2 clk = ~clk;

  gaussian_lobe_ward_reducer_unit u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_power(drv.power), .in_mean_x(drv.mean_x), .in_mean_y(drv.mean_y),
    .in_mean_z(drv.mean_z), .in_spread(drv.spread),
    .in_box_low_x(drv.low_x), .in_box_low_y(drv.low_y), .in_box_low_z(drv.low_z),
    .in_box_high_x(drv.high_x), .in_box_high_y(drv.high_y), .in_box_high_z(drv.high_z),
    .in_last_lobe(in_last_lobe),
    .out_valid(out_valid), .out_power(out_power), .out_mean_x(out_mean_x),
    .out_mean_y(out_mean_y), .out_mean_z(out_mean_z), .out_spread(out_spread),
    .out_low_x(out_low_x), .out_low_y(out_low_y), .out_low_z(out_low_z),
    .out_high_x(out_high_x), .out_high_y(out_high_y), .out_high_z(out_high_z),
    .out_last(out_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_result({out_power, out_mean_x, out_mean_y, out_mean_z, out_spread,
                       out_low_x, out_low_y, out_low_z, out_high_x, out_high_y,
                       out_high_z}, out_last);
  end

  function automatic logic [31:0] rand_word(int mode);
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      default: return mode == 0 ? $urandom() : $urandom_range(0, 32'h00FF_FFFF) -
                                               32'h0080_0000;
    endcase
  endfunction

  function automatic lobe_t rand_lobe();
    lobe_t l;
    int m;
    m = $urandom_range(0, 2);
    l.power = m == 0 ? rand_word(0) : $urandom_range(0, 32'h000F_FFFF);
    l.mean_x = rand_word(m);
    l.mean_y = rand_word(m);
    l.mean_z = rand_word(m);
    l.spread = rand_word(m);
    l.low_x = rand_word(m);
    l.low_y = rand_word(m);
    l.low_z = rand_word(m);
    l.high_x = rand_word(m);
    l.high_y = rand_word(m);
    l.high_z = rand_word(m);
    return l;
  endfunction

  // idle length after a word: mostly none, sometimes short, rarely long
  function automatic int gap_cycles();
    return $urandom_range(0, 9) < 6 ? 0 : ($urandom_range(0, 9) < 8 ?
           $urandom_range(1, 3) : $urandom_range(10, 40));
  endfunction

  // send one lobe word; waits until the block takes it, then may idle a while
  task automatic send_lobe(lobe_t l, bit last);
    int n;
    start <= 1;
    drv <= l;
    in_last_lobe <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_lobe(l, last);
    n = gap_cycles();
    if (n != 0) begin
      start <= 0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic write_target(logic [TGT_W-1:0] value);
    cfg_valid <= 1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.target_reg = value;
    cfg_valid <= 0;
  endtask

  task automatic drain();
    start <= 0;
    while (sb.expected_q.size() != 0 || busy) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic send_set(int n);
    for (int i = 0; i < n; i++) send_lobe(rand_lobe(), i == n - 1);
  endtask

  initial begin
    lobe_t l;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: default target, zero power pair, ties, extremes
    l = '0;
    send_lobe(l, 0);
    send_lobe(l, 0);
    send_lobe(l, 1);
    drain();
    l = '1;
    send_lobe(l, 0);
    l.mean_x = 32'h8000_0000; l.power = 32'h8000_0000;
    send_lobe(l, 0);
    l = '0; l.mean_y = 32'h7FFF_FFFF; l.power = 32'h1_0000; l.spread = 32'hFFFF_FFFF;
    send_lobe(l, 1);
    drain();
    // single lobe set and an overfull set with target zero and max
    write_target(0);
    send_lobe(rand_lobe(), 1);
    send_set(10);
    drain();
    write_target(7);
    send_set(10);
    drain();
    write_target(MAX_LOBES);
    send_set(3);
    drain();
    // random sets across targets
    for (int s = 0; s < NUM_SETS; s++) begin
      if ($urandom_range(0, 3) == 0) begin
        drain();
        write_target(TGT_W'($urandom_range(0, 7)));
      end
      send_set($urandom_range(0, 4) == 0 ? $urandom_range(9, 11) : $urandom_range(1, 8));
    end
    drain();
    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire
